FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DTPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define DTPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define DTPD_ASSERT(lbl, clk, rst_n, prop)
`define DTPD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/dtpd_pkg.sv
`default_nettype none
package dtpd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEN_W    = 10;
  localparam int THR_W    = 16;
  localparam int TIME_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [2:0] KIND_RIM   = 3'd2;
  localparam logic [2:0] KIND_HIHAT = 3'd3;

  typedef enum logic [1:0] {
    AUX_IDLE    = 2'd0,
    AUX_PEAK    = 2'd1,
    AUX_PRESSED = 2'd2
  } aux_state_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_KIND = 3'd0,
    REG_AUX_IS_PEDAL = 3'd1,
    REG_MIN_LEN      = 3'd2,
    REG_MAX_LEN      = 3'd3,
    REG_VOLUME_NORM  = 3'd4,
    REG_HIT_SPACING  = 3'd5,
    REG_BASE_THR     = 3'd6,
    REG_AUX_HOLDOFF  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]          channel_kind;
    logic                aux_is_pedal;
    logic [LEN_W-1:0]    min_peak_length;
    logic [LEN_W-1:0]    max_peak_length;
    logic [8:0]          volume_norm;
    logic [15:0]         hit_spacing;
    logic [SAMPLE_W-1:0] base_threshold;
    logic [TIME_W-1:0]   aux_holdoff;
  } cfg_t;

  typedef struct packed {
    logic                event_hit;
    logic [SAMPLE_W-1:0] height;
    logic [LEN_W-1:0]    length;
    logic                alternate;
  } hit_t;

  typedef struct packed {
    logic       event_aux;
    logic       level;
    aux_state_t state_code;
  } aux_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/dtpd_in_if.sv
`default_nettype none
interface dtpd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dtpd_pkg::SAMPLE_W-1:0]        adc_sample;
  logic                                 aux_pin;
  logic [dtpd_pkg::TIME_W-1:0]          time_now;

  modport source (output valid, adc_sample, aux_pin, time_now, input ready);
  modport sink   (input valid, adc_sample, aux_pin, time_now, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dtpd_out_if.sv
`default_nettype none
interface dtpd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit_event;
  logic [dtpd_pkg::SAMPLE_W-1:0] hit_height;
  logic [dtpd_pkg::LEN_W-1:0]    hit_length;
  logic                          hit_alternate;
  logic                          aux_event;
  logic                          aux_level;
  logic [1:0]                    aux_state_code;

  modport source (output valid, hit_event, hit_height, hit_length, hit_alternate,
                  aux_event, aux_level, aux_state_code, input ready);
  modport sink   (input valid, hit_event, hit_height, hit_length, hit_alternate,
                  aux_event, aux_level, aux_state_code, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/drum_trigger_peak_detector.sv
// Channel   Dir  Handshake              Word
// in_ch     in   valid/ready            adc_sample, aux_pin, time_now
// out_ch    out  valid/ready            hit_*, aux_event, aux_level, aux_state_code
// cfg_*     in   APB, pready tied high  8 registers at 4*i
//
// One word per cycle unless out_ch stalls; input register, then result register.
// The peak and aux state advance in the cycle a word moves into the result register.
// A stalled result holds; the input register still takes one more word behind it.
// Reset is synchronous; it clears state and restores the configuration defaults at once.
`default_nettype none
`include "assert_macros.svh"
module drum_trigger_peak_detector (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  dtpd_in_if.sink                          in_ch,
  dtpd_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [dtpd_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [dtpd_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [dtpd_pkg::DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  dtpd_pkg::cfg_t       cfg;
  dtpd_pkg::hit_t       hit, hit_r;
  dtpd_pkg::aux_res_t   aux, aux_r;
  dtpd_pkg::aux_state_t aux_cur_state;

  logic                          s1_valid_r, out_valid_r;
  logic [dtpd_pkg::SAMPLE_W-1:0] sample_r;
  logic                          pin_r;
  logic [dtpd_pkg::TIME_W-1:0]   time_r;
  logic                          advance, step;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  dtpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dtpd_main u_main (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .cfg           (cfg),
    .sample        (sample_r),
    .aux_cur_state (aux_cur_state),
    .hit           (hit)
  );

  dtpd_aux u_aux (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .cfg           (cfg),
    .pin           (pin_r),
    .time_now      (time_r),
    .aux           (aux),
    .aux_cur_state (aux_cur_state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r <= in_ch.adc_sample;
      pin_r    <= in_ch.aux_pin;
      time_r   <= in_ch.time_now;
    end
    if (step) begin
      hit_r <= hit;
      aux_r <= aux;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit_event      = hit_r.event_hit;
  assign out_ch.hit_height     = hit_r.height;
  assign out_ch.hit_length     = hit_r.length;
  assign out_ch.hit_alternate  = hit_r.alternate;
  assign out_ch.aux_event      = aux_r.event_aux;
  assign out_ch.aux_level      = aux_r.level;
  assign out_ch.aux_state_code = aux_r.state_code;

  `DTPD_ASSERT(a_hit_nonzero, clk, rst_n, out_valid_r && hit_r.event_hit |-> hit_r.length != '0 && hit_r.height != '0)
  `DTPD_ASSERT(a_no_hit_clean, clk, rst_n, out_valid_r && !hit_r.event_hit |-> hit_r.height == '0 && hit_r.length == '0 && !hit_r.alternate)
  `DTPD_ASSERT(a_press_state, clk, rst_n, out_valid_r && aux_r.event_aux && aux_r.level |-> aux_r.state_code == dtpd_pkg::AUX_PRESSED)
  `DTPD_ASSERT(a_stall_cause, clk, rst_n, !in_ch.ready |-> out_valid_r && !out_ch.ready && s1_valid_r)

endmodule
`default_nettype wire

FILE: rtl/core/dtpd_regs.sv
`default_nettype none
module dtpd_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dtpd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [dtpd_pkg::DATA_W-1:0] pwdata,
  output logic      [dtpd_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output dtpd_pkg::cfg_t                   cfg
);

  dtpd_pkg::cfg_t     cfg_r;
  dtpd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = dtpd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_kind    <= 3'd0;
      cfg_r.aux_is_pedal    <= 1'b0;
      cfg_r.min_peak_length <= 10'd3;
      cfg_r.max_peak_length <= 10'd201;
      cfg_r.volume_norm     <= 9'd50;
      cfg_r.hit_spacing     <= 16'd1500;
      cfg_r.base_threshold  <= 12'd100;
      cfg_r.aux_holdoff     <= 32'd500;
    end else if (wr_en) begin
      case (idx)
        dtpd_pkg::REG_CHANNEL_KIND: cfg_r.channel_kind    <= pwdata[2:0];
        dtpd_pkg::REG_AUX_IS_PEDAL: cfg_r.aux_is_pedal    <= pwdata[0];
        dtpd_pkg::REG_MIN_LEN:      cfg_r.min_peak_length <= pwdata[9:0];
        dtpd_pkg::REG_MAX_LEN:      cfg_r.max_peak_length <= pwdata[9:0];
        dtpd_pkg::REG_VOLUME_NORM:  cfg_r.volume_norm     <= pwdata[8:0];
        dtpd_pkg::REG_HIT_SPACING:  cfg_r.hit_spacing     <= pwdata[15:0];
        dtpd_pkg::REG_BASE_THR:     cfg_r.base_threshold  <= pwdata[11:0];
        dtpd_pkg::REG_AUX_HOLDOFF:  cfg_r.aux_holdoff     <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dtpd_pkg::REG_CHANNEL_KIND: prdata = {29'd0, cfg_r.channel_kind};
      dtpd_pkg::REG_AUX_IS_PEDAL: prdata = {31'd0, cfg_r.aux_is_pedal};
      dtpd_pkg::REG_MIN_LEN:      prdata = {22'd0, cfg_r.min_peak_length};
      dtpd_pkg::REG_MAX_LEN:      prdata = {22'd0, cfg_r.max_peak_length};
      dtpd_pkg::REG_VOLUME_NORM:  prdata = {23'd0, cfg_r.volume_norm};
      dtpd_pkg::REG_HIT_SPACING:  prdata = {16'd0, cfg_r.hit_spacing};
      dtpd_pkg::REG_BASE_THR:     prdata = {20'd0, cfg_r.base_threshold};
      dtpd_pkg::REG_AUX_HOLDOFF:  prdata = cfg_r.aux_holdoff;
      default:                    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/dtpd_main.sv
`default_nettype none
module dtpd_main (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire dtpd_pkg::cfg_t                cfg,
  input  wire logic [dtpd_pkg::SAMPLE_W-1:0] sample,
  input  wire dtpd_pkg::aux_state_t          aux_cur_state,
  output dtpd_pkg::hit_t                     hit
);

  localparam int SW = dtpd_pkg::SAMPLE_W;
  localparam int LW = dtpd_pkg::LEN_W;
  localparam int TW = dtpd_pkg::THR_W;

  logic [15:0]   cd_r, cd_nxt, cd_dec;
  logic          in_peak_r, in_peak_nxt;
  logic [SW-1:0] max_r, max_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [SW-1:0] last_r, last_nxt;

  logic signed [17:0] window_s, cd_s;
  logic [16:0]        prod;
  logic [TW-1:0]      thresh;
  logic               above, new_peak, peak_end, is_short, is_loud;
  logic [LW-1:0]      len_st, len_inc;
  logic [SW-1:0]      max_st, max_upd;

  assign cd_dec   = (cd_r != 16'd0) ? cd_r - 16'd1 : cd_r;
  assign window_s = $signed({2'b00, cfg.hit_spacing}) - 18'sd512;
  assign cd_s     = $signed({2'b00, cd_dec});
  assign prod     = 17'(last_r[SW-1:5]) * 17'(cd_dec[15:6]);

  always_comb begin
    if (cd_r == 16'd0) begin
      thresh = TW'(cfg.base_threshold);
    end else if (in_peak_r) begin
      thresh = TW'(1);
    end else if (cd_s > window_s) begin
      thresh = TW'({last_r, 1'b0});
    end else begin
      thresh = prod[16] ? {TW{1'b1}} : prod[15:0];
    end
  end

  assign above    = TW'(sample) > thresh;
  assign new_peak = cd_s < window_s;
  assign len_st   = new_peak ? '0 : len_r;
  assign len_inc  = (len_st != dtpd_pkg::LEN_MAX) ? len_st + LW'(1) : len_st;
  assign max_st   = new_peak ? '0 : max_r;
  assign max_upd  = (sample > max_st) ? sample : max_st;
  assign peak_end = sample < (max_upd >> 1);
  assign is_short = len_inc < cfg.min_peak_length;
  assign is_loud  = max_upd > SW'({cfg.volume_norm, 3'b000});

  always_comb begin
    cd_nxt      = cd_dec;
    in_peak_nxt = in_peak_r;
    len_nxt     = len_r;
    max_nxt     = max_r;
    last_nxt    = last_r;
    hit         = '0;
    if (above) begin
      if (new_peak) begin
        in_peak_nxt = 1'b1;
        cd_nxt      = cfg.hit_spacing;
      end
      len_nxt = len_inc;
      max_nxt = max_upd;
      if (peak_end) begin
        in_peak_nxt = 1'b0;
        if (is_short && is_loud) begin
          if (cfg.channel_kind == dtpd_pkg::KIND_RIM) begin
            hit.event_hit = 1'b1;
            hit.alternate = 1'b1;
          end
        end else if (!is_short && (len_inc < cfg.max_peak_length)) begin
          hit.event_hit = 1'b1;
          hit.alternate = (cfg.channel_kind == dtpd_pkg::KIND_HIHAT) &&
                          (aux_cur_state == dtpd_pkg::AUX_PRESSED);
        end else begin
          cd_nxt   = '0;
          last_nxt = '0;
        end
        if (hit.event_hit) begin
          hit.height = max_upd;
          hit.length = len_inc;
          last_nxt   = max_upd;
        end
        len_nxt = '0;
        max_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r      <= '0;
      in_peak_r <= 1'b0;
      max_r     <= '0;
      len_r     <= '0;
      last_r    <= '0;
    end else if (step) begin
      cd_r      <= cd_nxt;
      in_peak_r <= in_peak_nxt;
      max_r     <= max_nxt;
      len_r     <= len_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dtpd_aux.sv
`default_nettype none
module dtpd_aux (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire dtpd_pkg::cfg_t              cfg,
  input  wire logic                        pin,
  input  wire logic [dtpd_pkg::TIME_W-1:0] time_now,
  output dtpd_pkg::aux_res_t               aux,
  output dtpd_pkg::aux_state_t             aux_cur_state
);

  localparam int TW = dtpd_pkg::TIME_W;

  logic                 prev_r;
  dtpd_pkg::aux_state_t status_r, status_nxt;
  logic [TW-1:0]        last_r, last_nxt;
  logic [TW-1:0]        elapsed;
  logic                 holdoff_ok, level;

  assign elapsed       = time_now - last_r;
  assign holdoff_ok    = elapsed > cfg.aux_holdoff;
  assign level         = cfg.aux_is_pedal ? ~pin : pin;
  assign aux_cur_state = status_r;

  always_comb begin
    status_nxt    = status_r;
    last_nxt      = last_r;
    aux.event_aux = 1'b0;
    aux.level     = 1'b0;
    if (!cfg.aux_is_pedal) begin
      if (level && !prev_r) begin
        status_nxt = dtpd_pkg::AUX_PEAK;
      end
      if (!level && prev_r) begin
        if (holdoff_ok) begin
          aux.event_aux = 1'b1;
          last_nxt      = time_now;
        end
        status_nxt = dtpd_pkg::AUX_IDLE;
      end
    end else if (level != prev_r) begin
      if (holdoff_ok) begin
        aux.event_aux = 1'b1;
        aux.level     = level;
        last_nxt      = time_now;
      end
      status_nxt = level ? dtpd_pkg::AUX_PRESSED : dtpd_pkg::AUX_IDLE;
    end
    aux.state_code = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b0;
      status_r <= dtpd_pkg::AUX_IDLE;
      last_r   <= '0;
    end else if (step) begin
      prev_r   <= level;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/drum_trigger_peak_detector_test.sv
`timescale 1ns / 100ps

module drum_trigger_peak_detector_test;

  localparam logic [2:0] KIND_OTHER    = 3'd0;
  localparam logic [2:0] KIND_PAD      = 3'd1;
  localparam logic [2:0] KIND_TWO_ZONE = 3'd4;
  localparam logic [2:0] KIND_MUTE     = 3'd5;
  localparam logic [2:0] KIND_SPARE6   = 3'd6;
  localparam logic [2:0] KIND_SPARE7   = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    dtpd_pkg::hit_t     hit;
    dtpd_pkg::aux_res_t aux;
  } tick_t;

  class trigger_scoreboard;
    dtpd_pkg::cfg_t       cfg;
    logic [15:0]          cooldown;
    logic                 in_peak;
    logic [11:0]          peak_max;
    logic [9:0]           peak_len;
    logic [11:0]          last_height;
    logic                 aux_prev;
    dtpd_pkg::aux_state_t aux_cur_state;
    logic [31:0]          aux_stamp;
    tick_t                pending_ticks[$];
    int                   errors;

    function new();
      cfg.channel_kind    = KIND_OTHER;
      cfg.aux_is_pedal    = 1'b0;
      cfg.min_peak_length = 10'd3;
      cfg.max_peak_length = 10'd201;
      cfg.volume_norm     = 9'd50;
      cfg.hit_spacing     = 16'd1500;
      cfg.base_threshold  = 12'd100;
      cfg.aux_holdoff     = 32'd500;
      cooldown      = '0;
      in_peak       = 1'b0;
      peak_max      = '0;
      peak_len      = '0;
      last_height   = '0;
      aux_prev      = 1'b0;
      aux_cur_state = dtpd_pkg::AUX_IDLE;
      aux_stamp     = '0;
      errors        = 0;
    endfunction

    function void set_reg(dtpd_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        dtpd_pkg::REG_CHANNEL_KIND: cfg.channel_kind    = val[2:0];
        dtpd_pkg::REG_AUX_IS_PEDAL: cfg.aux_is_pedal    = val[0];
        dtpd_pkg::REG_MIN_LEN:      cfg.min_peak_length = val[9:0];
        dtpd_pkg::REG_MAX_LEN:      cfg.max_peak_length = val[9:0];
        dtpd_pkg::REG_VOLUME_NORM:  cfg.volume_norm     = val[8:0];
        dtpd_pkg::REG_HIT_SPACING:  cfg.hit_spacing     = val[15:0];
        dtpd_pkg::REG_BASE_THR:     cfg.base_threshold  = val[11:0];
        dtpd_pkg::REG_AUX_HOLDOFF:  cfg.aux_holdoff     = val;
        default: ;
      endcase
    endfunction

    function void predict_tick(logic [11:0] sample, logic pin, logic [31:0] now);
      int          window;
      logic [31:0] thresh;
      logic [31:0] prod;
      logic        level;
      logic        holdoff_ok;
      tick_t       r;
      r = '0;
      window = int'(cfg.hit_spacing) - 512;
      thresh = 32'(cfg.base_threshold);
      if (cooldown != 0) begin
        cooldown = cooldown - 16'd1;
        if (in_peak) begin
          thresh = 32'd1;
        end else if (int'(cooldown) > window) begin
          thresh = 32'(last_height) << 1;
        end else begin
          prod = (32'(last_height) >> 5) * (32'(cooldown) >> 6);
          thresh = (prod > 32'hFFFF) ? 32'hFFFF : prod;
        end
      end

      if (32'(sample) > thresh) begin
        if (int'(cooldown) < window) begin
          in_peak  = 1'b1;
          cooldown = cfg.hit_spacing;
          peak_len = '0;
          peak_max = '0;
        end
        if (peak_len != dtpd_pkg::LEN_MAX) peak_len = peak_len + 10'd1;
        if (sample > peak_max) peak_max = sample;
        if (sample < (peak_max >> 1)) begin
          in_peak = 1'b0;
          if (peak_len < cfg.min_peak_length && peak_max > {cfg.volume_norm, 3'b000}) begin
            if (cfg.channel_kind == dtpd_pkg::KIND_RIM) begin
              r.hit.event_hit = 1'b1;
              r.hit.alternate = 1'b1;
            end
          end else if (peak_len >= cfg.min_peak_length &&
                       peak_len < cfg.max_peak_length) begin
            r.hit.event_hit = 1'b1;
            r.hit.alternate = (cfg.channel_kind == dtpd_pkg::KIND_HIHAT &&
                               aux_cur_state == dtpd_pkg::AUX_PRESSED);
          end else begin
            cooldown    = '0;
            last_height = '0;
          end
          if (r.hit.event_hit) begin
            r.hit.height = peak_max;
            r.hit.length = peak_len;
            last_height  = peak_max;
          end
          peak_len = '0;
          peak_max = '0;
        end
      end

      holdoff_ok = (now - aux_stamp) > cfg.aux_holdoff;
      if (!cfg.aux_is_pedal) begin
        level = pin;
        if (level && !aux_prev) aux_cur_state = dtpd_pkg::AUX_PEAK;
        if (!level && aux_prev) begin
          if (holdoff_ok) begin
            r.aux.event_aux = 1'b1;
            r.aux.level     = 1'b0;
            aux_stamp       = now;
          end
          aux_cur_state = dtpd_pkg::AUX_IDLE;
        end
      end else begin
        level = ~pin;
        if (level != aux_prev) begin
          if (holdoff_ok) begin
            r.aux.event_aux = 1'b1;
            r.aux.level     = level;
            aux_stamp       = now;
          end
          aux_cur_state = level ? dtpd_pkg::AUX_PRESSED : dtpd_pkg::AUX_IDLE;
        end
      end
      aux_prev = level;
      r.aux.state_code = aux_cur_state;
      pending_ticks.push_back(r);
    endfunction

    function void check_tick(tick_t got);
      tick_t want;
      logic  bad;
      if (pending_ticks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result word with nothing pending: %p", $realtime, got);
        return;
      end
      want = pending_ticks.pop_front();
      bad = (got.hit.event_hit !== want.hit.event_hit) ||
            (got.hit.height !== want.hit.height) ||
            (got.hit.length !== want.hit.length) ||
            (got.hit.alternate !== want.hit.alternate) ||
            (got.aux.event_aux !== want.aux.event_aux) ||
            (got.aux.level !== want.aux.level) ||
            (got.aux.state_code !== want.aux.state_code);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: expected hit %b h %0d len %0d alt %b aux %b lvl %b st %0d",
                   $realtime, want.hit.event_hit, want.hit.height, want.hit.length,
                   want.hit.alternate, want.aux.event_aux, want.aux.level,
                   want.aux.state_code);
          $display("%0t: actual   hit %b h %0d len %0d alt %b aux %b lvl %b st %0d",
                   $realtime, got.hit.event_hit, got.hit.height, got.hit.length,
                   got.hit.alternate, got.aux.event_aux, got.aux.level,
                   got.aux.state_code);
        end
      end
    endfunction

    function bit idle();
      return pending_ticks.size() == 0;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [dtpd_pkg::ADDR_W-1:0]   cfg_paddr;
  logic [dtpd_pkg::DATA_W-1:0]   cfg_pwdata;
  logic [dtpd_pkg::DATA_W-1:0]   cfg_prdata;
  logic                          cfg_pready;

  dtpd_in_if  in_bus();
  dtpd_out_if out_bus();

  trigger_scoreboard sb;
  tick_t             seen;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                words_sent = 0;
  logic              aux_now = 1'b0;
  logic [31:0]       stamp = '0;

  drum_trigger_peak_detector u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen.hit.event_hit  = out_bus.hit_event;
      seen.hit.height     = out_bus.hit_height;
      seen.hit.length     = out_bus.hit_length;
      seen.hit.alternate  = out_bus.hit_alternate;
      seen.aux.event_aux  = out_bus.aux_event;
      seen.aux.level      = out_bus.aux_level;
      seen.aux.state_code = dtpd_pkg::aux_state_t'(out_bus.aux_state_code);
      sb.check_tick(seen);
    end
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:  begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND:  begin send_idle_pct = 75; stall_pct = 0;  end
      IDLE_STALL: begin send_idle_pct = 0;  stall_pct = 75; end
      IDLE_BOTH:  begin send_idle_pct = 14; stall_pct = 14; end
      default: ;
    endcase
  endtask

  task automatic write_reg(dtpd_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(logic [2:0] kind, logic pedal, int min_len, int max_len,
                           int vol, int spacing, int base, logic [31:0] holdoff);
    write_reg(dtpd_pkg::REG_CHANNEL_KIND, 32'(kind));
    write_reg(dtpd_pkg::REG_AUX_IS_PEDAL, 32'(pedal));
    write_reg(dtpd_pkg::REG_MIN_LEN, 32'(min_len));
    write_reg(dtpd_pkg::REG_MAX_LEN, 32'(max_len));
    write_reg(dtpd_pkg::REG_VOLUME_NORM, 32'(vol));
    write_reg(dtpd_pkg::REG_HIT_SPACING, 32'(spacing));
    write_reg(dtpd_pkg::REG_BASE_THR, 32'(base));
    write_reg(dtpd_pkg::REG_AUX_HOLDOFF, holdoff);
  endtask

  task automatic send_word(logic [11:0] sample, logic pin, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.adc_sample <= sample;
    in_bus.aux_pin    <= pin;
    in_bus.time_now   <= now;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.predict_tick(sample, pin, now);
    words_sent++;
  endtask

  task automatic send_tick(logic [11:0] sample);
    if ($urandom_range(5) == 0) aux_now = ~aux_now;
    case ($urandom_range(49))
      0:       stamp = $urandom();
      1, 2:    stamp = stamp + $urandom_range(400, 1200);
      default: stamp = stamp + $urandom_range(0, 30);
    endcase
    send_word(sample, aux_now, stamp);
  endtask

  // hold the sender until every pending word is back
  task automatic drain_pipe();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (!sb.idle()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int n_words);
    int target;
    int height;
    int span;
    int gap;
    int quiet;
    target = words_sent + n_words;
    while (words_sent < target) begin
      if ($urandom_range(7) == 0) begin
        send_tick(12'($urandom_range(4095)));
      end else begin
        case ($urandom_range(3))
          0:       height = $urandom_range(6, 4095);
          1:       height = 4095;
          2:       height = $urandom_range(100, 600);
          default: height = $urandom_range(1500, 4095);
        endcase
        span = ($urandom_range(4) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 12);
        send_tick(12'(height));
        for (int k = 1; k < span; k++) send_tick(12'($urandom_range(height, height / 2)));
        if ($urandom_range(5) == 0) send_tick(12'd0);
        else send_tick(12'($urandom_range(2, height / 2 - 1)));
        case ($urandom_range(2))
          0:       quiet = 1;
          1:       quiet = 40;
          default: quiet = 150;
        endcase
        gap = ($urandom_range(24) == 0) ? $urandom_range(480, 560) : $urandom_range(0, 20);
        if (words_sent + gap > target) gap = (target > words_sent) ? target - words_sent : 0;
        repeat (gap) send_tick(12'($urandom_range(quiet, 0)));
      end
      if ($urandom_range(150) == 0) drain_pipe();
    end
  endtask

  initial begin
    sb = new();
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    in_bus.valid      = 1'b0;
    in_bus.adc_sample = '0;
    in_bus.aux_pin    = 1'b0;
    in_bus.time_now   = '0;
    out_bus.ready     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturate the peak length
    apply_cfg(dtpd_pkg::KIND_RIM, 1'b0, 10, 1023, 5, 0, 100, 32'd500);
    set_idling(IDLE_NONE);
    repeat (1030) send_tick(12'd4095);
    send_tick(12'd1000);

    drain_pipe();
    apply_cfg(dtpd_pkg::KIND_RIM, 1'b0, 3, 6, 50, 513, 100, 32'd0);
    send_word(12'd0,    1'b0, 32'd0);
    send_word(12'd450,  1'b1, 32'd5);
    send_word(12'd100,  1'b0, 32'd6);
    send_word(12'd4095, 1'b1, 32'd7);
    send_word(12'd4095, 1'b1, 32'd7);
    send_word(12'd4095, 1'b1, 32'd8);
    send_word(12'd4095, 1'b1, 32'd9);
    send_word(12'd4095, 1'b1, 32'd10);
    send_word(12'd4095, 1'b1, 32'd10);
    send_word(12'd4095, 1'b1, 32'd10);
    send_word(12'd1900, 1'b0, 32'd10);
    send_word(12'd1,    1'b1, 32'd10);
    send_word(12'd2000, 1'b0, 32'd10);
    send_word(12'd2500, 1'b0, 32'd11);
    send_word(12'd2200, 1'b0, 32'd12);
    send_word(12'd800,  1'b0, 32'd13);
    send_word(12'd0,    1'b1, 32'hFFFF_FFFF);
    send_word(12'd4095, 1'b0, 32'h0000_0000);
    send_word(12'd0,    1'b1, 32'h0000_0001);
    aux_now = 1'b1;
    stamp   = 32'd1;

    drain_pipe();
    apply_cfg(KIND_PAD, 1'b0, 8, 30, 50, 513, 100, 32'd500);
    set_idling(IDLE_NONE);
    random_phase(70);

    drain_pipe();
    apply_cfg(dtpd_pkg::KIND_RIM, 1'b1, 3, 20, 0, 600, 0, 32'd20);
    set_idling(IDLE_SEND);
    random_phase(70);

    drain_pipe();
    apply_cfg(KIND_MUTE, 1'b1, 2, 15, 20, 100, 30, 32'd200);
    set_idling(IDLE_STALL);
    random_phase(60);

    drain_pipe();
    apply_cfg(KIND_SPARE6, 1'b0, 3, 12, 40, 0, 20, 32'd1000);
    set_idling(IDLE_BOTH);
    random_phase(60);

    drain_pipe();
    apply_cfg(KIND_SPARE7, 1'b1, 4, 25, 30, 513, 0, 32'd100);
    set_idling(IDLE_SEND);
    random_phase(60);

    drain_pipe();
    apply_cfg(dtpd_pkg::KIND_HIHAT, 1'b1, 3, 40, 50, 700, 60, 32'd50);
    set_idling(IDLE_STALL);
    random_phase(70);

    drain_pipe();
    apply_cfg(KIND_OTHER, 1'b0, 3, 201, 50, 1500, 100, 32'd500);
    set_idling(IDLE_NONE);
    random_phase(70);

    drain_pipe();
    apply_cfg(KIND_TWO_ZONE, 1'b0, 1023, 1, 10, 1500, 4095, 32'hFFFF_FFFF);
    set_idling(IDLE_BOTH);
    random_phase(30);

    drain_pipe();
    apply_cfg(dtpd_pkg::KIND_HIHAT, 1'b1, 1, 1023, 511, 65535, 50, 32'd0);
    set_idling(IDLE_SEND);
    random_phase(60);

    drain_pipe();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.idle()) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: drum_trigger_peak_detector.f
+incdir+rtl/core
rtl/core/dtpd_pkg.sv
rtl/core/dtpd_in_if.sv
rtl/core/dtpd_out_if.sv
rtl/core/dtpd_regs.sv
rtl/core/dtpd_main.sv
rtl/core/dtpd_aux.sv
rtl/core/drum_trigger_peak_detector.sv
tb/sv/drum_trigger_peak_detector_test.sv
